// File: rtl/mqpd_pkg.sv
package mqpd_pkg;

	localparam int OPCODE_W = 1;
	localparam int QID_W    = 3;
	localparam int PRIO_W   = 4;
	localparam int OUT_DOC_W = 16;
	localparam int QSLOTS   = 1 << QID_W;

	localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

endpackage

// File: rtl/mqpd_cell.sv
module mqpd_cell #(
	parameter int DOC_W = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mqpd_pkg::cmd_t                cmd,
	input  logic [DOC_W-1:0]              new_doc,
	input  logic                          left_ge,
	input  logic                          left_valid,
	input  logic [mqpd_pkg::PRIO_W-1:0]   left_prio,
	input  logic [DOC_W-1:0]              left_doc,
	input  logic                          right_valid,
	input  logic [mqpd_pkg::PRIO_W-1:0]   right_prio,
	input  logic [DOC_W-1:0]              right_doc,
	output logic                          ge,
	output logic                          valid,
	output logic [mqpd_pkg::PRIO_W-1:0]   prio,
	output logic [DOC_W-1:0]              doc
);

	logic                        valid_q;
	logic [mqpd_pkg::PRIO_W-1:0] prio_q;
	logic [DOC_W-1:0]            doc_q;

	// entries are sorted, so ge is a prefix along the row
	assign ge    = valid_q && (prio_q >= cmd.prio);
	assign valid = valid_q;
	assign prio  = prio_q;
	assign doc   = doc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !ge) begin
			valid_q <= left_ge ? 1'b1 : left_valid;
		end else if (cmd.rem) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !ge) begin
			if (left_ge) begin
				prio_q <= cmd.prio;
				doc_q  <= new_doc;
			end else begin
				prio_q <= left_prio;
				doc_q  <= left_doc;
			end
		end else if (cmd.rem) begin
			prio_q <= right_prio;
			doc_q  <= right_doc;
		end
	end

endmodule

// File: rtl/mqpd_row.sv
module mqpd_row #(
	parameter int DEPTH = 16,
	parameter int DOC_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mqpd_pkg::cmd_t   cmd,
	input  logic [DOC_W-1:0] new_doc,
	output logic             head_valid,
	output logic [DOC_W-1:0] head_doc
);

	logic                        ge    [DEPTH];
	logic                        valid [DEPTH];
	logic [mqpd_pkg::PRIO_W-1:0] prio  [DEPTH];
	logic [DOC_W-1:0]            doc   [DEPTH];
	mqpd_pkg::cmd_t              cell_cmd;

	// insert into a full queue is dropped
	always_comb begin
		cell_cmd     = cmd;
		cell_cmd.ins = cmd.ins && !valid[DEPTH-1];
		cell_cmd.rem = cmd.rem && valid[0];
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic                        l_ge;
		logic                        l_valid;
		logic [mqpd_pkg::PRIO_W-1:0] l_prio;
		logic [DOC_W-1:0]            l_doc;
		logic                        r_valid;
		logic [mqpd_pkg::PRIO_W-1:0] r_prio;
		logic [DOC_W-1:0]            r_doc;

		if (k == 0) begin : g_first
			assign l_ge    = 1'b1;
			assign l_valid = 1'b1;
			assign l_prio  = '0;
			assign l_doc   = '0;
		end else begin : g_mid
			assign l_ge    = ge[k-1];
			assign l_valid = valid[k-1];
			assign l_prio  = prio[k-1];
			assign l_doc   = doc[k-1];
		end

		if (k == DEPTH-1) begin : g_last
			assign r_valid = 1'b0;
			assign r_prio  = '0;
			assign r_doc   = '0;
		end else begin : g_inner
			assign r_valid = valid[k+1];
			assign r_prio  = prio[k+1];
			assign r_doc   = doc[k+1];
		end

		mqpd_cell #(
			.DOC_W(DOC_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.new_doc    (new_doc),
			.left_ge    (l_ge),
			.left_valid (l_valid),
			.left_prio  (l_prio),
			.left_doc   (l_doc),
			.right_valid(r_valid),
			.right_prio (r_prio),
			.right_doc  (r_doc),
			.ge         (ge[k]),
			.valid      (valid[k]),
			.prio       (prio[k]),
			.doc        (doc[k])
		);
	end

	assign head_valid = valid[0];
	assign head_doc   = doc[0];

endmodule

// File: rtl/multi_queue_priority_dispatcher.sv
// Result: a remove gives its result in the cycle after it is accepted, with done
// high for exactly that cycle; an insert gives no result.
// Throughput: one item per cycle; every queue is a row of sorted shift cells that
// updates all its cells in parallel on an insert or remove, so busy never rises.
// Reset: arst_n clears every cell's valid bit at once and sets the document counter to 1.
module multi_queue_priority_dispatcher #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int DOC_WIDTH   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [mqpd_pkg::OPCODE_W-1:0]       opcode,
	input  logic [mqpd_pkg::QID_W-1:0]          queue_id,
	input  logic [mqpd_pkg::PRIO_W-1:0]         priority_req,
	output logic                                done,
	output logic [mqpd_pkg::OUT_DOC_W-1:0]      doc_number,
	output logic                                is_null
);

	localparam int NQ_USED = (NUM_QUEUES < mqpd_pkg::QSLOTS) ? NUM_QUEUES : mqpd_pkg::QSLOTS;
	localparam logic [DOC_WIDTH-1:0] DOC_MAX = '1;

	logic                  accept;
	logic                  is_ins;
	logic                  is_rem;
	logic                  exhausted_q;
	logic [DOC_WIDTH-1:0]  next_doc_q;
	logic                  head_valid [mqpd_pkg::QSLOTS];
	logic [DOC_WIDTH-1:0]  head_doc   [mqpd_pkg::QSLOTS];
	logic                  done_q;
	logic                  is_null_q;
	logic [mqpd_pkg::OUT_DOC_W-1:0] doc_number_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_ins = accept && (opcode == mqpd_pkg::OP_INSERT) && !exhausted_q;
	assign is_rem = accept && (opcode == mqpd_pkg::OP_REMOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_doc_q  <= DOC_WIDTH'(1);
			exhausted_q <= 1'b0;
		end else if (is_ins) begin
			if (next_doc_q == DOC_MAX) begin
				exhausted_q <= 1'b1;
			end else begin
				next_doc_q <= next_doc_q + DOC_WIDTH'(1);
			end
		end
	end

	for (genvar q = 0; q < mqpd_pkg::QSLOTS; q++) begin : g_queue
		if (q < NQ_USED) begin : g_row
			mqpd_pkg::cmd_t row_cmd;
			logic           hit;

			assign hit          = (queue_id == mqpd_pkg::QID_W'(q));
			assign row_cmd.ins  = is_ins && hit;
			assign row_cmd.rem  = is_rem && hit;
			assign row_cmd.prio = priority_req;

			mqpd_row #(
				.DEPTH(QUEUE_DEPTH),
				.DOC_W(DOC_WIDTH)
			) u_row (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (row_cmd),
				.new_doc   (next_doc_q),
				.head_valid(head_valid[q]),
				.head_doc  (head_doc[q])
			);
		end else begin : g_none
			assign head_valid[q] = 1'b0;
			assign head_doc[q]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= is_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (is_rem) begin
			is_null_q    <= !head_valid[queue_id];
			doc_number_q <= head_valid[queue_id] ?
				mqpd_pkg::OUT_DOC_W'(head_doc[queue_id]) : '0;
		end
	end

	assign done       = done_q;
	assign doc_number = doc_number_q;
	assign is_null    = is_null_q;

	a_done_follows_remove: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(arst_n) && $past(start && opcode == mqpd_pkg::OP_REMOVE))
		else $error("result strobe without a remove transfer");

	a_null_has_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_null |-> doc_number == '0)
		else $error("null result carries a document number");

	a_exhausted_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(exhausted_q) |-> exhausted_q && $stable(next_doc_q))
		else $error("document counter moved after exhaustion");

	a_counter_steps: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(is_ins) && $past(next_doc_q) != DOC_MAX
		|-> next_doc_q == $past(next_doc_q) + DOC_WIDTH'(1))
		else $error("document counter did not advance on insert");

endmodule
